[rtl/ldcw_pkg.sv]
package ldcw_pkg;

  typedef enum logic [3:0] {
    OP_XY_OFF        = 4'd0,
    OP_XY_ON         = 4'd1,
    OP_X_OFF_DELAY   = 4'd2,
    OP_X_ON_DELAY    = 4'd3,
    OP_X_OFF         = 4'd4,
    OP_X_ON          = 4'd5,
    OP_Y_OFF_DELAY   = 4'd6,
    OP_Y_ON_DELAY    = 4'd7,
    OP_Y_OFF         = 4'd8,
    OP_Y_ON          = 4'd9,
    OP_PERM_DELAY    = 4'd10,
    OP_ONCE_DELAY    = 4'd11,
    OP_LASER_ON_DLY  = 4'd12,
    OP_LASER_OFF_DLY = 4'd13,
    OP_QSW_PERIOD    = 4'd14,
    OP_QSW_DURATION  = 4'd15
  } opcode_t;

  localparam logic [7:0] KIND_XY_OFF   = 8'h40;
  localparam logic [7:0] KIND_XY_ON    = 8'hC0;
  localparam logic [7:0] KIND_AXIS_OFF = 8'h60;
  localparam logic [7:0] KIND_AXIS_ON  = 8'hE0;
  localparam logic [7:0] KIND_DELAY    = 8'h20;
  localparam logic [7:0] KIND_QSW      = 8'h03;

  localparam logic [7:0] SUB_X_DELAY   = 8'h00;
  localparam logic [7:0] SUB_Y_DELAY   = 8'h01;
  localparam logic [7:0] SUB_X_MOVE    = 8'h02;
  localparam logic [7:0] SUB_Y_MOVE    = 8'h03;
  localparam logic [7:0] SUB_PERM      = 8'h00;
  localparam logic [7:0] SUB_ONCE      = 8'h04;
  localparam logic [7:0] SUB_LASER_ON  = 8'h02;
  localparam logic [7:0] SUB_LASER_OFF = 8'h03;
  localparam logic [7:0] SUB_QSW_PER   = 8'h04;
  localparam logic [7:0] SUB_QSW_DUR   = 8'h05;

  localparam logic [15:0] QSW_PER_OFS  = 16'd147;
  localparam logic [15:0] QSW_DUR_OFS  = 16'd6;
  localparam logic [16:0] ROUND_OFS    = 17'd5;

  // floor(n/3) = (n * RECIP3) >> 23 for n < 2^22
  localparam logic [21:0] RECIP3       = 22'd2796203;
  // floor(n/5) = (n * RECIP5) >> 18 for n < 2^16
  localparam logic [15:0] RECIP5       = 16'd52429;

  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam logic [7:0] SCALE_RESET   = 8'd1;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] value_a;
    logic [15:0] value_b;
  } in_t;

  typedef struct packed {
    logic [7:0] cmd_byte0;
    logic [7:0] cmd_byte1;
    logic [7:0] cmd_byte2;
    logic [7:0] cmd_byte3;
    logic [7:0] check_byte;
  } out_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       use_word;
    logic [7:0] crc;
  } hdr_t;

  function automatic logic [7:0] crc8_tab(input logic [7:0] idx);
    logic [7:0] c;
    c = idx;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/ldcw_hdr.sv]
module ldcw_hdr (
  input  ldcw_pkg::in_t  in_i,
  output ldcw_pkg::hdr_t hdr_o
);
  import ldcw_pkg::*;

  logic [11:0] x_off;
  logic [11:0] y_off;

  assign x_off = in_i.value_a[15:4];
  assign y_off = in_i.value_b[15:4];

  always_comb begin
    hdr_o          = '0;
    hdr_o.use_word = 1'b1;
    case (in_i.opcode)
      OP_XY_OFF: begin
        hdr_o.byte0    = KIND_XY_OFF | {4'h0, x_off[11:8]};
        hdr_o.byte1    = x_off[7:0];
        hdr_o.byte2    = {4'h0, y_off[11:8]};
        hdr_o.byte3    = y_off[7:0];
        hdr_o.use_word = 1'b0;
      end
      OP_XY_ON: begin
        hdr_o.byte0    = KIND_XY_ON | {4'h0, in_i.value_a[11:8]};
        hdr_o.byte1    = in_i.value_a[7:0];
        hdr_o.byte2    = {4'h0, in_i.value_b[11:8]};
        hdr_o.byte3    = in_i.value_b[7:0];
        hdr_o.use_word = 1'b0;
      end
      OP_X_OFF_DELAY: begin
        hdr_o.byte0 = KIND_AXIS_OFF;
        hdr_o.byte1 = SUB_X_DELAY;
      end
      OP_X_ON_DELAY: begin
        hdr_o.byte0 = KIND_AXIS_ON;
        hdr_o.byte1 = SUB_X_DELAY;
      end
      OP_X_OFF: begin
        hdr_o.byte0 = KIND_AXIS_OFF;
        hdr_o.byte1 = SUB_X_MOVE;
      end
      OP_X_ON: begin
        hdr_o.byte0 = KIND_AXIS_ON;
        hdr_o.byte1 = SUB_X_MOVE;
      end
      OP_Y_OFF_DELAY: begin
        hdr_o.byte0 = KIND_AXIS_OFF;
        hdr_o.byte1 = SUB_Y_DELAY;
      end
      OP_Y_ON_DELAY: begin
        hdr_o.byte0 = KIND_AXIS_ON;
        hdr_o.byte1 = SUB_Y_DELAY;
      end
      OP_Y_OFF: begin
        hdr_o.byte0 = KIND_AXIS_OFF;
        hdr_o.byte1 = SUB_Y_MOVE;
      end
      OP_Y_ON: begin
        hdr_o.byte0 = KIND_AXIS_ON;
        hdr_o.byte1 = SUB_Y_MOVE;
      end
      OP_PERM_DELAY: begin
        hdr_o.byte0 = KIND_DELAY;
        hdr_o.byte1 = SUB_PERM;
      end
      OP_ONCE_DELAY: begin
        hdr_o.byte0 = KIND_DELAY;
        hdr_o.byte1 = SUB_ONCE;
      end
      OP_LASER_ON_DLY: begin
        hdr_o.byte0 = KIND_DELAY;
        hdr_o.byte1 = SUB_LASER_ON;
      end
      OP_LASER_OFF_DLY: begin
        hdr_o.byte0 = KIND_DELAY;
        hdr_o.byte1 = SUB_LASER_OFF;
      end
      OP_QSW_PERIOD: begin
        hdr_o.byte0 = KIND_QSW;
        hdr_o.byte1 = SUB_QSW_PER;
      end
      default: begin
        hdr_o.byte0 = KIND_QSW;
        hdr_o.byte1 = SUB_QSW_DUR;
      end
    endcase
    hdr_o.crc = crc8_tab(crc8_tab(hdr_o.byte0) ^ hdr_o.byte1);
  end

endmodule

[rtl/ldcw_word.sv]
module ldcw_word (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  ldcw_pkg::in_t  in_i,
  input  ldcw_pkg::hdr_t hdr_i,
  input  logic [7:0]     scale_i,
  output logic           vld_o,
  output ldcw_pkg::hdr_t hdr_o,
  output logic [15:0]    word_o
);
  import ldcw_pkg::*;

  logic        s1_vld_r;
  logic        s1_vld_nxt;
  hdr_t        s1_hdr_r;
  logic [3:0]  s1_op_r;
  logic [15:0] s1_va_r;
  logic [23:0] s1_prod_r;
  logic [23:0] s1_prod_nxt;
  logic [7:0]  s1_lsr_r;
  logic [7:0]  s1_lsr_nxt;

  logic        s2_vld_r;
  hdr_t        s2_hdr_r;
  logic [15:0] s2_word_r;
  logic [15:0] s2_word_nxt;

  logic [16:0] rnd_sum;
  logic [31:0] rnd_prod;
  logic [43:0] div_prod;
  logic [15:0] div_q;

  assign s1_vld_nxt  = vld_i;
  assign s1_prod_nxt = {16'h0, scale_i} * {8'h0, in_i.value_a};
  assign rnd_sum     = {1'b0, in_i.value_a} + ROUND_OFS;
  assign rnd_prod    = {16'h0, rnd_sum[16:1]} * {16'h0, RECIP5};
  assign s1_lsr_nxt  = rnd_prod[25:18];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_hdr_r  <= hdr_i;
    s1_op_r   <= in_i.opcode;
    s1_va_r   <= in_i.value_a;
    s1_prod_r <= s1_prod_nxt;
    s1_lsr_r  <= s1_lsr_nxt;
  end

  // divide by 12: drop two bits, then reciprocal of 3
  assign div_prod = {22'h0, s1_prod_r[23:2]} * {22'h0, RECIP3};
  assign div_q    = div_prod[38:23];

  always_comb begin
    case (s1_op_r)
      OP_PERM_DELAY, OP_ONCE_DELAY: begin
        s2_word_nxt = 16'h0 - div_q;
      end
      OP_LASER_ON_DLY, OP_LASER_OFF_DLY: begin
        s2_word_nxt = {8'h00, s1_lsr_r};
      end
      OP_QSW_PERIOD: begin
        s2_word_nxt = s1_prod_r[15:0] - QSW_PER_OFS;
      end
      OP_QSW_DURATION: begin
        s2_word_nxt = s1_prod_r[15:0] - QSW_DUR_OFS;
      end
      default: begin
        s2_word_nxt = s1_va_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_hdr_r  <= s1_hdr_r;
    s2_word_r <= s2_word_nxt;
  end

  assign vld_o  = s2_vld_r;
  assign hdr_o  = s2_hdr_r;
  assign word_o = s2_word_r;

endmodule

[rtl/laser_command_word_encoder.sv]
// Encodes one marker command per clock: start with busy low takes a beat, and
// the four command bytes plus CRC-8 appear on out_data with out_valid high for
// exactly one cycle, once the beat has passed the datapath stages. busy is
// always low, so commands may arrive every cycle. The datapath stages are the
// input register, scale multiply, reciprocal divide-by-12, then byte assembly
// with the CRC tail and the output register. The receiver cannot stall, so
// each strobed beat must be taken when shown. Write cfg_wdata
// (clock_scale, reset value 1) only while no command is in flight.
module laser_command_word_encoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ldcw_pkg::in_t  in_data,
  output logic           out_valid,
  output ldcw_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);
  import ldcw_pkg::*;

  logic [7:0]  scale_r;
  logic [7:0]  scale_nxt;
  logic        in_vld_r;
  in_t         in_r;
  hdr_t        hdr;
  logic        wd_vld;
  hdr_t        wd_hdr;
  logic [15:0] wd_word;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic        out_valid_r;
  out_t        out_r;
  out_t        out_nxt;

  assign busy      = 1'b0;
  assign scale_nxt = cfg_we ? cfg_wdata : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      in_vld_r <= 1'b0;
    end else begin
      scale_r  <= scale_nxt;
      in_vld_r <= start && !busy;
    end
    in_r <= in_data;
  end

  ldcw_hdr u_hdr (
    .in_i  (in_r),
    .hdr_o (hdr)
  );

  ldcw_word u_word (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_vld_r),
    .in_i    (in_r),
    .hdr_i   (hdr),
    .scale_i (scale_r),
    .vld_o   (wd_vld),
    .hdr_o   (wd_hdr),
    .word_o  (wd_word)
  );

  assign b2 = wd_hdr.use_word ? wd_word[15:8] : wd_hdr.byte2;
  assign b3 = wd_hdr.use_word ? wd_word[7:0]  : wd_hdr.byte3;

  always_comb begin
    out_nxt            = '0;
    out_nxt.cmd_byte0  = wd_hdr.byte0;
    out_nxt.cmd_byte1  = wd_hdr.byte1;
    out_nxt.cmd_byte2  = b2;
    out_nxt.cmd_byte3  = b3;
    out_nxt.check_byte = crc8_tab(crc8_tab(wd_hdr.crc ^ b2) ^ b3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= wd_vld;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted beat lost in pipeline");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result strobe without accepted beat");

endmodule
